// ===== src/signed_gadget_decompose_macros.svh =====
// Assertion macros shared by the signed gadget decomposition RTL.
`ifndef SIGNED_GADGET_DECOMPOSE_MACROS_SVH
`define SIGNED_GADGET_DECOMPOSE_MACROS_SVH

`ifndef ASSERT_OFF
`define SGD_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define SGD_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define SGD_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define SGD_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif

`endif

// ===== src/sgd_pkg.sv =====
// Shared types and constants for the signed gadget decomposition block.
`default_nettype none

package sgd_pkg;

  localparam int Q_W      = 63;
  localparam int DB_W     = 6;
  localparam int LC_W     = 7;
  localparam int IDX_W    = 2;
  localparam int CFG_W    = 63;
  localparam int IN_W     = 64;
  localparam int OUT_W    = 64;
  localparam int LEVEL_W  = 6;
  localparam int DIGIT_MAX = 32;

  typedef enum logic [IDX_W-1:0] {
    REG_MODULUS     = 2'd0,
    REG_DIGIT_BITS  = 2'd1,
    REG_LEVEL_COUNT = 2'd2
  } reg_idx_t;

  // Sanitized configuration seen by the datapath
  typedef struct packed {
    logic [Q_W-1:0]  q;       // 1 .. 2^63-1
    logic [DB_W-1:0] bits;    // 1 .. 32
    logic [LC_W-1:0] levels;  // 1 .. MAX_LEVELS
  } sgd_cfg_t;

  // Reduced coefficient handed from the modulo pipeline to the digit emitter
  typedef struct packed {
    logic           valid;
    logic [Q_W-1:0] rem;
  } sgd_rem_t;

endpackage

`default_nettype wire

// ===== src/sgd_mod_pipe.sv =====
// Bit-per-stage pipelined remainder unit: coefficient mod q.
`default_nettype none

module sgd_mod_pipe #(
  parameter int COEFF_BITS = 64
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [COEFF_BITS-1:0] in_coeff,
  input  wire logic [sgd_pkg::Q_W-1:0] q,
  output sgd_pkg::sgd_rem_t          out,
  input  wire logic                  out_ready
);
  import sgd_pkg::*;

  localparam int N = COEFF_BITS;

  logic                  vld [N];
  logic [Q_W-1:0]        r   [N];
  logic [N-1:0]          dv  [N-1];
  logic                  adv;

  assign adv      = !vld[N-1] || out_ready;
  assign in_ready = adv;

  genvar k;
  generate
    for (k = 0; k < N; k++) begin : g_stage
      logic [Q_W-1:0] pr;
      logic [N-1:0]   pd;
      logic           pv;
      logic [Q_W:0]   t;
      logic [Q_W:0]   ts;

      if (k == 0) begin : g_first
        assign pr = '0;
        assign pd = in_coeff;
        assign pv = in_valid;
      end else begin : g_rest
        assign pr = r[k-1];
        assign pd = dv[k-1];
        assign pv = vld[k-1];
      end

      // partial remainder stays below q, so one conditional subtract suffices
      assign t  = {pr, pd[N-1]};
      assign ts = t - {1'b0, q};

      always_ff @(posedge clk) begin
        if (rst) begin
          vld[k] <= 1'b0;
        end else if (adv) begin
          vld[k] <= pv;
        end
      end

      always_ff @(posedge clk) begin
        if (adv) begin
          r[k] <= (t >= {1'b0, q}) ? ts[Q_W-1:0] : t[Q_W-1:0];
        end
      end

      if (k < N - 1) begin : g_shift
        always_ff @(posedge clk) begin
          if (adv) begin
            dv[k] <= pd << 1;
          end
        end
      end
    end
  endgenerate

  assign out.valid = vld[N-1];
  assign out.rem   = r[N-1];

endmodule

`default_nettype wire

// ===== src/sgd_digit_emit.sv =====
// Signed digit sequencer: one base-2^b digit residue per output beat.
`default_nettype none

module sgd_digit_emit #(
  parameter int MAX_LEVELS = 64
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire sgd_pkg::sgd_rem_t           in,
  output logic                             in_ready,
  input  wire sgd_pkg::sgd_cfg_t           cfg,
  output logic                             m_valid,
  input  wire logic                        m_ready,
  output logic [sgd_pkg::Q_W-1:0]          m_residue,
  output logic [sgd_pkg::LEVEL_W-1:0]      m_level,
  output logic                             m_last
);
  import sgd_pkg::*;

  localparam int LW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;

  logic                 busy;
  logic [Q_W-1:0]       rem;
  logic [LW-1:0]        lvl;

  logic                 out_free;
  logic                 fire;
  logic                 is_last;
  logic                 load;
  logic [DIGIT_MAX:0]   base;
  logic [DIGIT_MAX:0]   mask;
  logic [DIGIT_MAX:0]   half;
  logic [DIGIT_MAX-1:0] raw;
  logic                 neg;
  logic [Q_W:0]         res_w;
  logic [Q_W-1:0]       rem_next;

  always_comb begin
    out_free = !m_valid || m_ready;
    fire     = busy && out_free;
    is_last  = (LC_W'(lvl) == (cfg.levels - LC_W'(1)));
    in_ready = !busy || (fire && is_last);
    load     = in.valid && in_ready;

    base = (DIGIT_MAX+1)'(1) << cfg.bits;
    mask = base - (DIGIT_MAX+1)'(1);
    half = base >> 1;
    raw  = rem[DIGIT_MAX-1:0] & mask[DIGIT_MAX-1:0];
    neg  = |(raw & half[DIGIT_MAX-1:0]);

    // rem < q, so raw < q and base - raw <= raw < q: no further reduction
    if (neg) begin
      res_w = {1'b0, cfg.q} + (Q_W+1)'(raw) - (Q_W+1)'(base);
    end else begin
      res_w = (Q_W+1)'(raw);
    end
    rem_next = (rem >> cfg.bits) + Q_W'(neg);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      m_valid <= 1'b0;
    end else begin
      if (load) begin
        busy <= 1'b1;
      end else if (fire && is_last) begin
        busy <= 1'b0;
      end
      if (fire) begin
        m_valid <= 1'b1;
      end else if (m_ready) begin
        m_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      m_residue <= res_w[Q_W-1:0];
      m_level   <= LEVEL_W'(lvl);
      m_last    <= is_last;
    end
    if (load) begin
      rem <= in.rem;
      lvl <= '0;
    end else if (fire) begin
      rem <= rem_next;
      lvl <= lvl + LW'(1);
    end
  end

endmodule

`default_nettype wire

// ===== src/signed_gadget_decompose.sv =====
// Top level: signed base-2^b gadget decomposition of one coefficient per input beat.
//
//  channel  dir  handshake           payload
//  s_*      in   s_tvalid/s_tready   s_tdata = coefficient
//  m_*      out  m_tvalid/m_tready   m_tdata = digit_residue, m_tuser = level_index,
//                                    m_tlast = last_level
//  cfg_*    in   cfg_write           cfg_index, cfg_data (no read-back)
//
// A coefficient passes one remainder stage per coefficient bit, then the digit
// sequencer and its output register, before its first digit beat appears.
// A coefficient occupies the sequencer for one digit beat per level (level_count held
// to 1..MAX_LEVELS); the sequencer takes the next one as the last of those issues.
// rst clears all valid bits and reloads the register defaults.
// m_tready low while m_tvalid is high freezes the sequencer; the remainder pipeline then stalls as a
// whole once its last stage holds a beat, and s_tready drops.
`default_nettype none

module signed_gadget_decompose #(
  parameter int MAX_LEVELS = 64,
  parameter int COEFF_BITS = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // config write port
  input  wire logic                          cfg_write,
  input  wire logic [sgd_pkg::IDX_W-1:0]     cfg_index,
  input  wire logic [sgd_pkg::CFG_W-1:0]     cfg_data,
  // input stream
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [sgd_pkg::IN_W-1:0]      s_tdata,   // [63:0] coefficient
  // output stream
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic [sgd_pkg::OUT_W-1:0]          m_tdata,   // [62:0] digit_residue, [63] zero
  output logic [sgd_pkg::LEVEL_W-1:0]        m_tuser,   // [5:0] level_index
  output logic                               m_tlast    // last_level
);
  import sgd_pkg::*;

  `include "signed_gadget_decompose_macros.svh"

  logic [Q_W-1:0]  modulus;
  logic [DB_W-1:0] digit_bits;
  logic [LC_W-1:0] level_count;
  sgd_cfg_t        cfg;
  sgd_rem_t        rem_beat;
  logic            rem_ready;
  logic [Q_W-1:0]  residue;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus     <= Q_W'(132120577);
      digit_bits  <= DB_W'(7);
      level_count <= LC_W'(4);
    end else if (cfg_write) begin
      unique case (reg_idx_t'(cfg_index))
        REG_MODULUS:     modulus     <= cfg_data[Q_W-1:0];
        REG_DIGIT_BITS:  digit_bits  <= cfg_data[DB_W-1:0];
        REG_LEVEL_COUNT: level_count <= cfg_data[LC_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.q = (modulus == '0) ? Q_W'(1) : modulus;
    if (digit_bits == '0) begin
      cfg.bits = DB_W'(1);
    end else if (digit_bits > DB_W'(DIGIT_MAX)) begin
      cfg.bits = DB_W'(DIGIT_MAX);
    end else begin
      cfg.bits = digit_bits;
    end
    if (level_count == '0) begin
      cfg.levels = LC_W'(1);
    end else if (level_count > LC_W'(MAX_LEVELS)) begin
      cfg.levels = LC_W'(MAX_LEVELS);
    end else begin
      cfg.levels = level_count;
    end
  end

  sgd_mod_pipe #(
    .COEFF_BITS (COEFF_BITS)
  ) u_mod (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_coeff  (s_tdata[COEFF_BITS-1:0]),
    .q         (cfg.q),
    .out       (rem_beat),
    .out_ready (rem_ready)
  );

  sgd_digit_emit #(
    .MAX_LEVELS (MAX_LEVELS)
  ) u_emit (
    .clk       (clk),
    .rst       (rst),
    .in        (rem_beat),
    .in_ready  (rem_ready),
    .cfg       (cfg),
    .m_valid   (m_tvalid),
    .m_ready   (m_tready),
    .m_residue (residue),
    .m_level   (m_tuser),
    .m_last    (m_tlast)
  );

  assign m_tdata = OUT_W'(residue);

  `SGD_ASSERT_IMP(a_residue_below_q, clk, rst, m_tvalid, residue < cfg.q)
  `SGD_ASSERT_NXT(a_levels_consecutive, clk, rst, m_tvalid && m_tready && !m_tlast,
                  m_tvalid && (m_tuser == $past(m_tuser) + LEVEL_W'(1)))

endmodule

`default_nettype wire

// ===== tb/sgd_checker.sv =====
// Checker for signed_gadget_decompose: tracks config writes, predicts digit beats, compares.
module sgd_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic [sgd_pkg::IDX_W-1:0]    cfg_index,
  input  logic [sgd_pkg::CFG_W-1:0]    cfg_data,
  input  logic                         s_tvalid,
  input  logic                         s_tready,
  input  logic [sgd_pkg::IN_W-1:0]     s_tdata,
  input  logic                         m_tvalid,
  input  logic                         m_tready,
  input  logic [sgd_pkg::OUT_W-1:0]    m_tdata,
  input  logic [sgd_pkg::LEVEL_W-1:0]  m_tuser,
  input  logic                         m_tlast,
  output int                           mismatches,
  output int                           pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import sgd_pkg::*;

  localparam int MAX_LEVELS = 64;

  typedef struct packed {
    logic [Q_W-1:0]     residue;
    logic [LEVEL_W-1:0] level;
    logic               last;
  } digit_beat_t;

  digit_beat_t expected_digits[$];

  logic [Q_W-1:0]  modulus;
  logic [DB_W-1:0] digit_bits;
  logic [LC_W-1:0] level_count;

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  // Signed base-2^b digits of coeff mod q, queued lowest level first
  function automatic void decompose_coeff(input logic [IN_W-1:0] coeff);
    logic [63:0] q, base, mask, half, rest, raw, mag, res;
    int unsigned bits, levels;
    digit_beat_t beat;
    q = (modulus == '0) ? 64'd1 : {1'b0, modulus};
    bits = digit_bits;
    levels = level_count;
    if (bits < 1) bits = 1;
    if (bits > DIGIT_MAX) bits = DIGIT_MAX;
    if (levels < 1) levels = 1;
    if (levels > MAX_LEVELS) levels = MAX_LEVELS;
    base = 64'd1 << bits;
    mask = base - 64'd1;
    half = base >> 1;
    rest = coeff % q;
    for (int unsigned l = 0; l < levels; l++) begin
      raw = rest & mask;
      rest = rest >> bits;
      if (raw >= half) begin
        mag = (base - raw) % q;
        res = (mag == 64'd0) ? 64'd0 : q - mag;
        rest = rest + 64'd1;
      end else begin
        res = raw % q;
      end
      beat.residue = res[Q_W-1:0];
      beat.level = l[LEVEL_W-1:0];
      beat.last = (l + 1 == levels);
      expected_digits.push_back(beat);
    end
  endfunction

  always @(posedge clk) begin : monitor
    digit_beat_t want;
    if (rst) begin
      modulus = 63'd132120577;
      digit_bits = 6'd7;
      level_count = 7'd4;
      expected_digits.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_MODULUS:     modulus = cfg_data[Q_W-1:0];
          REG_DIGIT_BITS:  digit_bits = cfg_data[DB_W-1:0];
          REG_LEVEL_COUNT: level_count = cfg_data[LC_W-1:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) decompose_coeff(s_tdata);
      if (m_tvalid && m_tready) begin
        if (expected_digits.size() == 0) begin
          report_mismatch($sformatf("unexpected beat data=%h level=%0d last=%b",
                                    m_tdata, m_tuser, m_tlast));
        end else begin
          want = expected_digits.pop_front();
          if (m_tdata !== {{(OUT_W-Q_W){1'b0}}, want.residue})
            report_mismatch($sformatf("level %0d residue %h, want %h",
                                      want.level, m_tdata, want.residue));
          if (m_tuser !== want.level)
            report_mismatch($sformatf("level index %0d, want %0d", m_tuser, want.level));
          if (m_tlast !== want.last)
            report_mismatch($sformatf("level %0d last %b, want %b",
                                      want.level, m_tlast, want.last));
        end
      end
    end
    pending = expected_digits.size();
  end

endmodule

// ===== tb/tb_signed_gadget_decompose.sv =====
// Testbench top for signed_gadget_decompose: clock, reset, config and stream stimulus, verdict.
module tb_signed_gadget_decompose;
  timeunit 1ns;
  timeprecision 1ps;
  import sgd_pkg::*;

  localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int SINK_HOLD_CYCLES = 400;
  localparam int STALL_LIMIT = 4000;

  logic               clk = 1'b0;
  logic               rst;
  logic               cfg_write;
  logic [IDX_W-1:0]   cfg_index;
  logic [CFG_W-1:0]   cfg_data;
  logic               s_tvalid;
  logic               s_tready;
  logic [IN_W-1:0]    s_tdata;    // [63:0] coefficient
  logic               m_tvalid;
  logic               m_tready;
  logic [OUT_W-1:0]   m_tdata;    // [62:0] digit_residue, [63] zero
  logic [LEVEL_W-1:0] m_tuser;    // [5:0] level_index
  logic               m_tlast;

  int                 mismatches;
  int                 pending;

  bit                 burst_mode;
  bit                 sink_hold_req;
  logic [63:0]        cur_q;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  signed_gadget_decompose DUT (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast)
  );

  sgd_checker CHECK (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast),
    .mismatches(mismatches), .pending(pending)
  );

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    if (idx == REG_MODULUS) cur_q = (data == '0) ? 64'd1 : {1'b0, data};
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic send_coeff(input logic [IN_W-1:0] coeff);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, 12);
    repeat (gap) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata <= coeff;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  // Digit beat sink: random gaps per beat outside burst mode, one long hold-off on request
  initial begin : sink
    int gap;
    m_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (sink_hold_req) begin
        sink_hold_req = 1'b0;
        gap = SINK_HOLD_CYCLES;
      end else begin
        gap = burst_mode ? 0 : $urandom_range(0, 12);
      end
      repeat (gap) begin
        @(negedge clk);
        m_tready <= 1'b0;
      end
      @(negedge clk);
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle = 0;
      else idle++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    int n_items, lv, bits, k;
    logic [CFG_W-1:0] q_val;
    logic [63:0] wide, coeff;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    burst_mode = 1'b0;
    sink_hold_req = 1'b0;
    cur_q = 64'd132120577;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset defaults: q = 132120577, b = 7, four levels
    send_coeff(64'd0);
    send_coeff(64'd1);
    send_coeff(64'd63);
    send_coeff(64'd64);
    send_coeff(64'd127);
    send_coeff(64'd128);
    send_coeff(64'd132120576);
    send_coeff(64'd132120577);
    send_coeff(64'hFFFF_FFFF_FFFF_FFFF);
    send_coeff(64'h8000_0000_0000_0000);
    send_coeff(64'hAAAA_AAAA_AAAA_AAAA);
    send_coeff(64'h5555_5555_5555_5555);
    wait_idle();

    // widest modulus and digit
    write_reg(REG_MODULUS, 63'h7FFF_FFFF_FFFF_FFFF);
    write_reg(REG_DIGIT_BITS, 63'd32);
    write_reg(REG_LEVEL_COUNT, 63'd3);
    send_coeff(64'hFFFF_FFFF_FFFF_FFFF);
    send_coeff(64'h7FFF_FFFF_FFFF_FFFE);
    send_coeff(64'h0000_0000_8000_0000);
    send_coeff(64'h8000_0000_0000_0000);
    wait_idle();

    // one-bit digits, single level, then several
    write_reg(REG_MODULUS, 63'd3);
    write_reg(REG_DIGIT_BITS, 63'd1);
    write_reg(REG_LEVEL_COUNT, 63'd1);
    send_coeff(64'd1);
    send_coeff(64'd2);
    wait_idle();
    write_reg(REG_LEVEL_COUNT, 63'd5);
    send_coeff(64'd2);
    send_coeff(64'hFFFF_FFFF_FFFF_FFFF);
    wait_idle();

    // zero writes fall back to 1; a write past the register list is dropped
    write_reg(REG_MODULUS, 63'd0);
    write_reg(REG_DIGIT_BITS, 63'd0);
    write_reg(REG_LEVEL_COUNT, 63'd0);
    write_reg(REG_UNUSED, 63'({$urandom, $urandom}));
    send_coeff(64'hFFFF_FFFF_FFFF_FFFF);
    send_coeff(64'd12345);
    wait_idle();
    write_reg(REG_MODULUS, 63'd1);
    write_reg(REG_LEVEL_COUNT, 63'd2);
    send_coeff(64'hDEAD_BEEF_0123_4567);
    wait_idle();
    write_reg(REG_MODULUS, 63'd2);
    send_coeff(64'd1);
    wait_idle();

    // oversized digit width and level count saturate; upper data bits ignored
    write_reg(REG_MODULUS, (63'd1 << 40) + 63'd15);
    write_reg(REG_DIGIT_BITS, {57'h1A5_5A5A_5A5A_5A5A, 6'h3F});
    write_reg(REG_LEVEL_COUNT, 63'd127);
    send_coeff(64'hFFFF_FFFF_FFFF_FFFF);
    send_coeff({$urandom, $urandom});
    wait_idle();

    for (int r = 0; r < 11; r++) begin
      wide = {$urandom, $urandom};
      k = $urandom_range(1, 62);
      case ($urandom_range(0, 4))
        0: q_val = wide[CFG_W-1:0];
        1: q_val = 63'($urandom_range(2, 1000));
        2: q_val = 63'd1 << k;
        3: q_val = (63'd1 << k) + 63'($urandom_range(1, 99));
        default: q_val = 63'h7FFF_FFFF_FFFF_FFFF - 63'($urandom_range(0, 99));
      endcase
      bits = $urandom_range(1, 32);
      case ($urandom_range(0, 7))
        0: lv = $urandom_range(9, 64);
        1: lv = (63 + bits - 1) / bits + 1;
        default: lv = $urandom_range(1, 8);
      endcase
      if (r == 6) lv = 2;
      n_items = (r == 6) ? 100 : (lv > 8) ? 8 : 24;
      write_reg(REG_MODULUS, q_val);
      write_reg(REG_DIGIT_BITS, 63'(bits));
      write_reg(REG_LEVEL_COUNT, 63'(lv));
      burst_mode = (r == 3 || r == 6);
      if (r == 6) sink_hold_req = 1'b1;
      for (int i = 0; i < n_items; i++) begin
        if (r == 9 && i == n_items / 2) wait_idle();
        wide = {$urandom, $urandom};
        case ($urandom_range(0, 5))
          0: coeff = wide;
          1: coeff = 64'($urandom_range(0, 255));
          2: coeff = cur_q - 64'd1;
          3: coeff = cur_q + 64'($urandom_range(0, 255));
          4: coeff = wide % cur_q;
          default: coeff = wide | 64'hFFFF_FFFF_0000_0000;
        endcase
        send_coeff(coeff);
      end
      wait_idle();
    end
    burst_mode = 1'b0;

    wait_idle();
    repeat (80) @(negedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
